// ----- rtl/core/eqrr_pkg.sv -----
package eqrr_pkg;

    // Default values of the top-level parameters
    localparam int DEF_MAX_WIDTH      = 8192;
    localparam int DEF_MAX_HEIGHT     = 4096;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // Field widths of the transactions and registers
    localparam int ROW_W   = 12;
    localparam int COL_W   = 13;
    localparam int CFG_W   = 54;
    localparam int COEF_W  = 18;
    localparam int IMGW_W  = 14;
    localparam int IMGH_W  = 13;

    // Phase divider: 4 quotient bits per stage over a 48-bit dividend
    localparam int DIV_STEPS  = 4;
    localparam int DIV_NUM_W  = 48;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;
    localparam int DIV_REM_W  = 14;

    // CORDIC and square root
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
    localparam int SQRT_STEPS   = 31;
    localparam int SC_W         = 32;
    localparam int ANG_W        = 34;
    localparam int PROD_W       = COEF_W + SC_W;
    localparam int ACC_W        = PROD_W + 2;

    localparam logic [31:0] CORDIC_INV_GAIN = 32'd652032874;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint FULL_TURN    = 64'sd4294967296;
    localparam longint ONE_Q30      = 64'sd1073741824;

    localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Stage budget: divide, sin/cos, vector+matrix, acos prep, sqrt, atan2, scale
    localparam int RZ_DELAY   = 2 + SQRT_STEPS;
    localparam int AZ_DELAY   = 3 + SQRT_STEPS;
    localparam int PIPE_DEPTH = DIV_STAGES + CORDIC_LAT + 3 + 3 + SQRT_STEPS
                                + CORDIC_LAT + 2;

    typedef enum logic [2:0] {
        CFG_ROT_ROW0     = 3'd0,
        CFG_ROT_ROW1     = 3'd1,
        CFG_ROT_ROW2     = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
    } t_pix_in;

    typedef struct packed {
        logic [ROW_W-1:0] src_row;
        logic [COL_W-1:0] src_col;
        logic             in_range;
    } t_pix_out;

    // Four restoring division steps: returns {remainder, quotient bits}
    function automatic logic [DIV_REM_W+DIV_STEPS-1:0] div_step4(
        input logic [DIV_REM_W-1:0] rem,
        input logic [DIV_STEPS-1:0] bits,
        input logic [DIV_REM_W-1:0] dvs
    );
        logic [DIV_REM_W:0]   t;
        logic [DIV_REM_W-1:0] r;
        logic [DIV_STEPS-1:0] q;
        r = rem;
        q = '0;
        for (int k = DIV_STEPS - 1; k >= 0; k--) begin
            t = {r, bits[k]};
            if (t >= {1'b0, dvs}) begin
                t    = t - {1'b0, dvs};
                q[k] = 1'b1;
            end
            r = t[DIV_REM_W-1:0];
        end
        return {r, q};
    endfunction

endpackage

// ----- rtl/core/eqrr_cordic.sv -----
module eqrr_cordic import eqrr_pkg::*; #(
    parameter bit VECTOR = 1'b0,
    parameter int DW     = SC_W,
    parameter int ZW     = ANG_W
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    localparam logic signed [ZW-1:0] QUARTER = ZW'(QUARTER_TURN);
    localparam logic signed [ZW-1:0] HALF    = ZW'(HALF_TURN);

    logic signed [DW-1:0] r_x [CORDIC_ITERS+1];
    logic signed [DW-1:0] r_y [CORDIC_ITERS+1];
    logic signed [ZW-1:0] r_z [CORDIC_ITERS+1];
    logic                 r_f [CORDIC_ITERS+1];

    logic signed [DW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic                 n_f;

    logic signed [DW-1:0] r_px, r_py;
    logic signed [ZW-1:0] r_pz;

    // Fold into the convergence range: quadrant swap or half-turn fold
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        n_f = 1'b0;
        if (VECTOR) begin
            n_f = (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    n_x = i_y;
                    n_y = -i_x;
                    n_z = i_z + QUARTER;
                end else begin
                    n_x = -i_y;
                    n_y = i_x;
                    n_z = i_z - QUARTER;
                end
            end
        end else begin
            if (i_z > QUARTER) begin
                n_z = i_z - HALF;
                n_f = 1'b1;
            end else if (i_z < -QUARTER) begin
                n_z = i_z + HALF;
                n_f = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x;
            r_y[0] <= n_y;
            r_z[0] <= n_z;
            r_f[0] <= n_f;
        end
    end

    // One micro-rotation per stage
    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TURNS[g]);
        logic signed [DW-1:0] xs, ys;
        logic                 cw;

        assign xs = r_x[g] >>> g;
        assign ys = r_y[g] >>> g;
        assign cw = VECTOR ? (r_y[g] < 0) : (r_z[g] >= 0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[g+1] <= r_f[g];
                if (cw) begin
                    r_x[g+1] <= r_x[g] - ys;
                    r_y[g+1] <= r_y[g] + xs;
                    r_z[g+1] <= r_z[g] - ATAN;
                end else begin
                    r_x[g+1] <= r_x[g] + ys;
                    r_y[g+1] <= r_y[g] - xs;
                    r_z[g+1] <= r_z[g] + ATAN;
                end
            end
        end
    end

    // Undo the fold: negate after a half-turn, zero angle for a zero vector
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!VECTOR && r_f[CORDIC_ITERS]) begin
                r_px <= -r_x[CORDIC_ITERS];
                r_py <= -r_y[CORDIC_ITERS];
            end else begin
                r_px <= r_x[CORDIC_ITERS];
                r_py <= r_y[CORDIC_ITERS];
            end
            if (VECTOR && r_f[CORDIC_ITERS]) begin
                r_pz <= '0;
            end else begin
                r_pz <= r_z[CORDIC_ITERS];
            end
        end
    end

    assign o_x = r_px;
    assign o_y = r_py;
    assign o_z = r_pz;

endmodule

// ----- rtl/core/equirect_rotate_remap.sv -----
// Equirectangular rotation remap address generator.
// Input channel (i_in_valid / o_in_ready / i_in_data): one destination pixel
// per transaction. Output channel (o_out_valid / i_out_ready / o_out_data):
// the source pixel row and column for it, plus an in-range flag, in order.
// Configuration: i_cfg_we writes i_cfg_data into the register picked by
// i_cfg_idx (matrix rows 0..2, image width, image height); write only while
// no transaction is in flight.
// Throughput is one transaction per clock while the output is not stalled.
// The stages are 12 divider stages (4 quotient bits each), 32 stages of
// sin/cos CORDIC (a fold stage, one micro-rotation per middle stage and an
// unfold stage), 3 for vector and matrix products, 3 for the acos argument,
// 31 square-root stages (one root bit each), 32 stages of atan2 CORDIC and 2
// for scaling and saturation.
// Reset clears all pipeline valid bits and loads the identity matrix and a
// 4096 x 2048 image. When the receiver stalls with a result waiting, the
// whole pipeline holds and o_in_ready drops; no transaction is lost or
// repeated. While the output register is empty the block always accepts.
module equirect_rotate_remap import eqrr_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pix_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_pix_out         o_out_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int RW = ACC_W - COEF_FRAC_BITS;
    localparam int VW = RW + 2;
    localparam logic signed [ANG_W-1:0] HALF_T = ANG_W'(HALF_TURN);
    localparam logic signed [ANG_W-1:0] FULL_T = ANG_W'(FULL_TURN);

    // Configuration registers
    logic [CFG_W-1:0]  r_rot_row [3];
    logic [IMGW_W-1:0] r_img_w;
    logic [IMGH_W-1:0] r_img_h;
    logic [IMGW_W-1:0] w_eff;
    logic [IMGH_W-1:0] h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_row[0] <= CFG_W'(64'd65536);
            r_rot_row[1] <= CFG_W'(64'd65536 << 18);
            r_rot_row[2] <= CFG_W'(64'd65536 << 36);
            r_img_w      <= IMGW_W'(4096);
            r_img_h      <= IMGH_W'(2048);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_ROW0:     r_rot_row[0] <= i_cfg_data;
                CFG_ROT_ROW1:     r_rot_row[1] <= i_cfg_data;
                CFG_ROT_ROW2:     r_rot_row[2] <= i_cfg_data;
                CFG_IMAGE_WIDTH:  r_img_w      <= i_cfg_data[IMGW_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h      <= i_cfg_data[IMGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Use zero size as one, saturate to the maximum size
    always_comb begin
        if (r_img_w == '0) begin
            w_eff = IMGW_W'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w_eff = IMGW_W'(MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h == '0) begin
            h_eff = IMGH_W'(1);
        end else if (32'(r_img_h) > MAX_HEIGHT) begin
            h_eff = IMGH_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_img_h;
        end
    end

    // Pipeline control: every stage advances unless the output is stalled
    logic                  en;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign en          = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    // Phase division: polar = row*2^31/H, azimuth = col*2^32/W, modulo 2^32
    logic [DIV_REM_W-1:0] r_pr [DIV_STAGES];
    logic [DIV_REM_W-1:0] r_ar [DIV_STAGES];
    logic [31:0]          r_pq [DIV_STAGES];
    logic [31:0]          r_aq [DIV_STAGES];
    logic [DIV_NUM_W-1:0] r_pn [DIV_STAGES];
    logic [DIV_NUM_W-1:0] r_an [DIV_STAGES];
    logic [DIV_REM_W-1:0] h_div, w_div;

    assign h_div = DIV_REM_W'(h_eff);
    assign w_div = DIV_REM_W'(w_eff);

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        logic [DIV_REM_W-1:0]           pr_i, ar_i;
        logic [31:0]                    pq_i, aq_i;
        logic [DIV_NUM_W-1:0]           pn_i, an_i;
        logic [DIV_REM_W+DIV_STEPS-1:0] pstep, astep;

        if (s == 0) begin : g_head
            assign pr_i = '0;
            assign ar_i = '0;
            assign pq_i = '0;
            assign aq_i = '0;
            assign pn_i = DIV_NUM_W'({i_in_data.out_row, 31'b0});
            assign an_i = DIV_NUM_W'({i_in_data.out_col, 32'b0});
        end else begin : g_body
            assign pr_i = r_pr[s-1];
            assign ar_i = r_ar[s-1];
            assign pq_i = r_pq[s-1];
            assign aq_i = r_aq[s-1];
            assign pn_i = r_pn[s-1];
            assign an_i = r_an[s-1];
        end

        assign pstep = div_step4(pr_i, pn_i[DIV_NUM_W-1 -: DIV_STEPS], h_div);
        assign astep = div_step4(ar_i, an_i[DIV_NUM_W-1 -: DIV_STEPS], w_div);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pr[s] <= pstep[DIV_REM_W+DIV_STEPS-1:DIV_STEPS];
                r_ar[s] <= astep[DIV_REM_W+DIV_STEPS-1:DIV_STEPS];
                r_pq[s] <= {pq_i[31-DIV_STEPS:0], pstep[DIV_STEPS-1:0]};
                r_aq[s] <= {aq_i[31-DIV_STEPS:0], astep[DIV_STEPS-1:0]};
                r_pn[s] <= pn_i << DIV_STEPS;
                r_an[s] <= an_i << DIV_STEPS;
            end
        end
    end

    // Sine and cosine of both angles
    logic signed [SC_W-1:0] cos_p, sin_p, cos_a, sin_a;

    eqrr_cordic #(.VECTOR(1'b0), .DW(SC_W), .ZW(ANG_W)) u_sc_polar (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ($signed(CORDIC_INV_GAIN)),
        .i_y   ('0),
        .i_z   (ANG_W'($signed(r_pq[DIV_STAGES-1]))),
        .o_x   (cos_p),
        .o_y   (sin_p),
        .o_z   ()
    );

    eqrr_cordic #(.VECTOR(1'b0), .DW(SC_W), .ZW(ANG_W)) u_sc_azim (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   ($signed(CORDIC_INV_GAIN)),
        .i_y   ('0),
        .i_z   (ANG_W'($signed(r_aq[DIV_STAGES-1]))),
        .o_x   (cos_a),
        .o_y   (sin_a),
        .o_z   ()
    );

    // Unit vector on the sphere
    logic signed [2*SC_W-1:0] prod_vx, prod_vy;
    logic signed [SC_W-1:0]   r_v [3];

    assign prod_vx = sin_p * cos_a;
    assign prod_vy = sin_p * sin_a;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v[0] <= prod_vx[SC_W+29:30];
            r_v[1] <= prod_vy[SC_W+29:30];
            r_v[2] <= cos_p;
        end
    end

    // Rotate: products in one stage, row sums in the next
    logic signed [PROD_W-1:0] r_mp [3][3];
    logic signed [RW-1:0]     r_r  [3];

    for (genvar i = 0; i < 3; i++) begin : g_mat_row
        logic signed [ACC_W-1:0] acc;

        for (genvar k = 0; k < 3; k++) begin : g_mat_col
            logic signed [COEF_W-1:0] cf;
            assign cf = $signed(r_rot_row[i][COEF_W*k +: COEF_W]);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_mp[i][k] <= cf * r_v[k];
                end
            end
        end

        assign acc = ACC_W'(r_mp[i][0]) + ACC_W'(r_mp[i][1]) + ACC_W'(r_mp[i][2]);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_r[i] <= RW'(acc >>> COEF_FRAC_BITS);
            end
        end
    end

    // Clamp the acos argument, square it and form 1 - z^2
    logic signed [63:0]     rz_wide;
    logic signed [SC_W-1:0] r_rzc;
    logic signed [63:0]     rz_sq;
    logic [60:0]            r_sq;
    logic [61:0]            r_rad;

    assign rz_wide = 64'(r_r[2]);
    assign rz_sq   = r_rzc * r_rzc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (rz_wide > ONE_Q30) begin
                r_rzc <= SC_W'(ONE_Q30);
            end else if (rz_wide < -ONE_Q30) begin
                r_rzc <= SC_W'(-ONE_Q30);
            end else begin
                r_rzc <= SC_W'(rz_wide);
            end
            r_sq  <= rz_sq[60:0];
            r_rad <= (62'd1 << 60) - {1'b0, r_sq};
        end
    end

    // Hold the clamped z alongside the square root
    logic signed [SC_W-1:0] r_rzd [RZ_DELAY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rzd[0] <= r_rzc;
            for (int d = 1; d < RZ_DELAY; d++) begin
                r_rzd[d] <= r_rzd[d-1];
            end
        end
    end

    // Square root, one result bit per stage
    logic [34:0] r_srem [SQRT_STEPS];
    logic [30:0] r_sq_q [SQRT_STEPS];
    logic [61:0] r_srad [SQRT_STEPS];

    for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_sqrt
        logic [34:0] rem_i, rem_sh, trial;
        logic [30:0] q_i;
        logic [61:0] rad_i;

        if (t == 0) begin : g_head
            assign rem_i = '0;
            assign q_i   = '0;
            assign rad_i = r_rad;
        end else begin : g_body
            assign rem_i = r_srem[t-1];
            assign q_i   = r_sq_q[t-1];
            assign rad_i = r_srad[t-1];
        end

        assign rem_sh = {rem_i[32:0], rad_i[61:60]};
        assign trial  = {2'b00, q_i, 2'b01};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srad[t] <= rad_i << 2;
                if (rem_sh >= trial) begin
                    r_srem[t] <= rem_sh - trial;
                    r_sq_q[t] <= {q_i[29:0], 1'b1};
                end else begin
                    r_srem[t] <= rem_sh;
                    r_sq_q[t] <= {q_i[29:0], 1'b0};
                end
            end
        end
    end

    // Polar angle = atan2(sqrt(1 - z^2), z)
    logic signed [ANG_W-1:0] z_polar;

    eqrr_cordic #(.VECTOR(1'b1), .DW(ANG_W), .ZW(ANG_W)) u_vec_polar (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (ANG_W'(r_rzd[RZ_DELAY-1])),
        .i_y   ($signed(ANG_W'(r_sq_q[SQRT_STEPS-1]))),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (z_polar)
    );

    // Azimuth = atan2(y, x), then delay to meet the polar angle
    logic signed [ANG_W-1:0] z_azim;
    logic signed [ANG_W-1:0] r_azd [AZ_DELAY];

    eqrr_cordic #(.VECTOR(1'b1), .DW(VW), .ZW(ANG_W)) u_vec_azim (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (VW'(r_r[0])),
        .i_y   (VW'(r_r[1])),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (z_azim)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_azd[0] <= z_azim;
            for (int d = 1; d < AZ_DELAY; d++) begin
                r_azd[d] <= r_azd[d-1];
            end
        end
    end

    // Clamp and wrap the angles, scale back to pixels
    logic [31:0]      zp;
    logic [32:0]      za;
    logic [44:0]      row_prod;
    logic [46:0]      col_prod;
    logic [13:0]      r_srow;
    logic [14:0]      r_scol;
    t_pix_out         r_out;

    always_comb begin
        if (z_polar < 0) begin
            zp = '0;
        end else if (z_polar > HALF_T) begin
            zp = 32'(HALF_T);
        end else begin
            zp = z_polar[31:0];
        end
        if (r_azd[AZ_DELAY-1] < 0) begin
            za = 33'(r_azd[AZ_DELAY-1] + FULL_T);
        end else begin
            za = r_azd[AZ_DELAY-1][32:0];
        end
    end

    assign row_prod = zp * h_eff;
    assign col_prod = za * w_eff;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_srow <= row_prod[44:31];
            r_scol <= col_prod[46:32];
        end
    end

    // Flag out-of-image sources and saturate to the field widths
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.in_range <= (r_srow < 14'(h_eff)) && (r_scol < 15'(w_eff));
            r_out.src_row  <= (r_srow > 14'(4095)) ? '1 : r_srow[ROW_W-1:0];
            r_out.src_col  <= (r_scol > 15'(8191)) ? '1 : r_scol[COL_W-1:0];
        end
    end

    assign o_out_data = r_out;

endmodule

// ----- rtl/core/eqrr_checker.sv -----
module eqrr_checker import eqrr_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_pix_out o_out_data
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds the input side too
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // An empty output register never refuses a transaction
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_out_valid) |-> o_in_ready)
        else $error("input refused with empty output");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind equirect_rotate_remap eqrr_checker u_eqrr_checker (.*);

// ----- test/equirect_rotate_remap_test.sv -----
module equirect_rotate_remap_test;
    import eqrr_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             in_valid;
    logic             in_ready;
    t_pix_in          in_data;
    logic             out_valid;
    logic             out_ready;
    t_pix_out         out_data;
    logic             cfg_we;
    logic [2:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    equirect_rotate_remap i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    localparam int LATENCY   = PIPE_DEPTH;
    localparam int N_RANDOM  = 1100;
    localparam longint ONE_TURN = 64'sd4294967296;

    // Mirror of the block's registers
    logic [CFG_W-1:0]  mtx_row [3];
    logic [IMGW_W-1:0] img_w;
    logic [IMGH_W-1:0] img_h;

    t_pix_out remap_queue [$];
    int       n_errors;
    logic     long_stall_req;
    logic     long_stall_done;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Time limit for the whole run
    initial begin
        #(40_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Arithmetic shift right, rounding toward minus infinity
    function automatic longint shr_floor(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint coef_of(logic [CFG_W-1:0] row, int k);
        logic signed [COEF_W-1:0] c;
        c = row[COEF_W*k +: COEF_W];
        return longint'(c);
    endfunction

    // Rotation-mode CORDIC for a phase in 2^-32 turn
    function automatic void cordic_sincos(logic [31:0] phase, output longint c,
                                          output longint s);
        longint z, x, y, t;
        bit     flip;
        z = longint'(phase) - (phase[31] ? ONE_TURN : 0);
        x = longint'(CORDIC_INV_GAIN);
        y = 0;
        flip = 0;
        if (z > QUARTER_TURN) begin
            z -= HALF_TURN;
            flip = 1;
        end else if (z < -QUARTER_TURN) begin
            z += HALF_TURN;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            t = x;
            if (z >= 0) begin
                x -= shr_floor(y, i);
                y += shr_floor(t, i);
                z -= longint'(ATAN_TURNS[i]);
            end else begin
                x += shr_floor(y, i);
                y -= shr_floor(t, i);
                z += longint'(ATAN_TURNS[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Vectoring-mode CORDIC: atan2 in 2^-32 turn
    function automatic longint cordic_atan2(longint y, longint x);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end else begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            t = x;
            if (y >= 0) begin
                x += shr_floor(y, i);
                y -= shr_floor(t, i);
                z += longint'(ATAN_TURNS[i]);
            end else begin
                x -= shr_floor(y, i);
                y += shr_floor(t, i);
                z -= longint'(ATAN_TURNS[i]);
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Source pixel for one destination pixel under the current settings
    function automatic t_pix_out remap_pixel(t_pix_in px);
        longint unsigned w, h, srow, scol;
        logic [31:0]     pp, pa;
        longint          cp, sp, ca, sa, acc, zp, za, s;
        longint          v [3];
        longint          r [3];
        t_pix_out        res;
        w = (img_w == 0) ? 1 : (img_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : img_w);
        h = (img_h == 0) ? 1 : (img_h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : img_h);
        pp = 32'(((64'(px.out_row)) << 31) / h);
        pa = 32'(((64'(px.out_col)) << 32) / w);
        cordic_sincos(pp, cp, sp);
        cordic_sincos(pa, ca, sa);
        v[0] = shr_floor(sp * ca, 30);
        v[1] = shr_floor(sp * sa, 30);
        v[2] = cp;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += coef_of(mtx_row[i], k) * v[k];
            r[i] = shr_floor(acc, DEF_COEF_FRAC_BITS);
        end
        if (r[2] > ONE_Q30) r[2] = ONE_Q30;
        if (r[2] < -ONE_Q30) r[2] = -ONE_Q30;
        s = longint'(floor_sqrt((64'd1 << 60) - longint'(r[2] * r[2])));
        zp = cordic_atan2(s, r[2]);
        if (zp < 0) zp = 0;
        if (zp > HALF_TURN) zp = HALF_TURN;
        za = cordic_atan2(r[1], r[0]);
        if (za < 0) za += ONE_TURN;
        srow = (longint'(zp) * h) >> 31;
        scol = (longint'(za) * w) >> 32;
        res.in_range = (srow < h && scol < w);
        res.src_row  = (srow > 4095) ? 12'd4095 : srow[11:0];
        res.src_col  = (scol > 8191) ? 13'd8191 : scol[12:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // Write one register; only called with the pipeline empty
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_ROT_ROW0:     mtx_row[0] = val;
            CFG_ROT_ROW1:     mtx_row[1] = val;
            CFG_ROT_ROW2:     mtx_row[2] = val;
            CFG_IMAGE_WIDTH:  img_w = val[IMGW_W-1:0];
            CFG_IMAGE_HEIGHT: img_h = val[IMGH_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until the pipeline has drained
    task automatic drain();
        int guard;
        guard = 0;
        while (remap_queue.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Offer one transaction and hold it until accepted
    task automatic send_pixel(t_pix_in px, bit typed, t_pix_out want);
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        remap_queue.push_back(typed ? want : remap_pixel(px));
    endtask

    task automatic send_burst(int n, bit well_formed);
        t_pix_in  px;
        t_pix_out none;
        none = '0;
        for (int j = 0; j < n; j++) begin
            if (well_formed) begin
                px.out_row = 12'($urandom_range(0, (img_h == 0) ? 0 : img_h - 1));
                px.out_col = 13'($urandom_range(0, (img_w == 0) ? 0 : img_w - 1));
            end else begin
                px = t_pix_in'((ROW_W + COL_W)'($urandom));
            end
            send_pixel(px, 1'b0, none);
        end
        in_valid <= 1'b0;
    endtask

    // Random settings, extremes now and then
    task automatic random_settings();
        logic [CFG_W-1:0] v;
        for (int i = 0; i < 3; i++) begin
            v = CFG_W'({$urandom, $urandom});
            write_reg(t_cfg_idx'(i), v);
        end
        case ($urandom_range(0, 3))
            0: write_reg(CFG_IMAGE_WIDTH, 54'($urandom_range(1, 64)));
            1: write_reg(CFG_IMAGE_WIDTH, 54'(16383));
            default: write_reg(CFG_IMAGE_WIDTH, 54'($urandom_range(1, 8192)));
        endcase
        case ($urandom_range(0, 3))
            0: write_reg(CFG_IMAGE_HEIGHT, 54'($urandom_range(1, 32)));
            1: write_reg(CFG_IMAGE_HEIGHT, 54'(8191));
            default: write_reg(CFG_IMAGE_HEIGHT, 54'($urandom_range(1, 4096)));
        endcase
    endtask

    // Directed rows: coordinates, and a typed result where obvious
    typedef struct {
        logic [11:0] row;
        logic [12:0] col;
        bit          typed;
        t_pix_out    want;
    } t_pixel_case;

    t_pixel_case directed [] = '{
        '{12'd0,    13'd0,    1'b0, '0},
        '{12'd1024, 13'd0,    1'b0, '0},
        '{12'd1024, 13'd1024, 1'b0, '0},
        '{12'd2047, 13'd4095, 1'b0, '0},
        '{12'd4095, 13'd8191, 1'b0, '0},
        '{12'd2048, 13'd4096, 1'b0, '0},
        '{12'd4095, 13'd0,    1'b0, '0},
        '{12'd0,    13'd8191, 1'b0, '0},
        '{12'd1,    13'd1,    1'b0, '0},
        '{12'd3000, 13'd7000, 1'b0, '0},
        '{12'd2730, 13'd5461, 1'b0, '0},
        '{12'd1365, 13'd2730, 1'b0, '0}
    };

    // Check results in order
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (remap_queue.size() == 0) begin
                report_mismatch("pending transactions", 1, 0);
            end else begin
                want = remap_queue.pop_front();
                if (out_data.src_row != want.src_row)
                    report_mismatch("src_row", out_data.src_row, want.src_row);
                if (out_data.src_col != want.src_col)
                    report_mismatch("src_col", out_data.src_col, want.src_col);
                if (out_data.in_range != want.in_range)
                    report_mismatch("in_range", out_data.in_range, want.in_range);
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready       <= 1'b0;
            long_stall_done <= 1'b0;
        end else if (long_stall_req && !long_stall_done) begin
            out_ready <= 1'b0;
            for (int c = 0; c < 3 * LATENCY; c++) @(posedge i_clk);
            long_stall_done <= 1'b1;
            out_ready       <= 1'b1;
        end else begin
            case ($urandom_range(0, 7))
                0, 1:    out_ready <= 1'b0;
                default: out_ready <= ($urandom_range(0, 3) != 0) || remap_queue.size() < 8;
            endcase
        end
    end

    initial begin
        t_pix_in  px;
        t_pix_out none;
        int       total;
        none            = '0;
        n_errors        = 0;
        long_stall_req  = 1'b0;
        i_rst_n         = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_ROT_ROW0;
        cfg_data        = '0;
        mtx_row[0]      = 54'd65536;
        mtx_row[1]      = 54'd65536 << 18;
        mtx_row[2]      = 54'd65536 << 36;
        img_w           = 14'd4096;
        img_h           = 13'd2048;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at reset settings, back to back
        foreach (directed[n]) begin
            px.out_row = directed[n].row;
            px.out_col = directed[n].col;
            send_pixel(px, directed[n].typed, directed[n].want);
        end
        in_valid <= 1'b0;
        drain();

        // Zero size and extreme matrices
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, '0);
        write_reg(CFG_ROT_ROW0, '1);
        write_reg(CFG_ROT_ROW1, {3{18'h20000}});
        write_reg(CFG_ROT_ROW2, {3{18'h1FFFF}});
        for (int j = 0; j < 6; j++) begin
            send_pixel(t_pix_in'((ROW_W + COL_W)'($urandom)), 1'b0, none);
        end
        in_valid <= 1'b0;
        drain();

        // Oversize image, permuted matrix
        write_reg(CFG_IMAGE_WIDTH, 54'(16383));
        write_reg(CFG_IMAGE_HEIGHT, 54'(8191));
        write_reg(CFG_ROT_ROW0, 54'd65536 << 36);
        write_reg(CFG_ROT_ROW1, 54'd65536);
        write_reg(CFG_ROT_ROW2, 54'd65536 << 18);
        px = '0;
        send_pixel(px, 1'b0, none);
        px = '1;
        send_pixel(px, 1'b0, none);

        // Long receiver hold-off while input keeps coming
        long_stall_req = 1'b1;
        send_burst(3 * LATENCY, 1'b1);
        drain();

        // Random phases: bursts and gaps, new settings between phases
        total = 0;
        while (total < N_RANDOM) begin
            int n;
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_ROT_ROW0, 54'd65536);
                write_reg(CFG_ROT_ROW1, 54'd65536 << 18);
                write_reg(CFG_ROT_ROW2, 54'd65536 << 36);
                write_reg(CFG_IMAGE_WIDTH, 54'(4096));
                write_reg(CFG_IMAGE_HEIGHT, 54'(2048));
            end else begin
                random_settings();
            end
            for (int b = 0; b < 8; b++) begin
                n = $urandom_range(1, 40);
                send_burst(n, $urandom_range(0, 4) != 0);
                total += n;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            drain();
        end

        if (n_errors == 0 && remap_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/eqrr_pkg.sv
rtl/core/eqrr_cordic.sv
rtl/core/equirect_rotate_remap.sv
rtl/core/eqrr_checker.sv
test/equirect_rotate_remap_test.sv
